/* rtl/core/bdra_pkg.sv */
`default_nettype none

package bdra_pkg;

    localparam int BDRA_DEPTH      = 64;
    localparam int BDRA_DATA_WIDTH = 32;
    localparam int CMDQ_DEPTH      = 2;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_REMOVE,
        CMD_NOP
    } t_cmd_kind;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_POP_EMPTY  = 2'd1,
        STAT_PUSH_FULL  = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_POP_WAIT,
        BK_SCAN
    } t_back_state;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] data_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [6:0]         removed_count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic               is_empty;
        logic               is_full;
        logic [6:0]         entry_count;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/bdra_front.sv */
`default_nettype none

module bdra_front
    import bdra_pkg::*;
#(
    parameter int DATA_WIDTH = BDRA_DATA_WIDTH
) (
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_item                 i_item,
    output logic                       o_cmd_valid,
    input  wire logic                  i_cmd_ready,
    output t_cmd_kind                  o_cmd_kind,
    output logic [DATA_WIDTH-1:0]      o_cmd_value
);

    logic [63:0] value_wide;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;

    // only the low data bits are stored and compared
    assign value_wide  = 64'($unsigned(i_item.data_value));
    assign o_cmd_value = value_wide[DATA_WIDTH-1:0];

    always_comb begin
        case (i_item.operation)
            OP_PUSH_FRONT: o_cmd_kind = CMD_PUSH_FRONT;
            OP_PUSH_BACK:  o_cmd_kind = CMD_PUSH_BACK;
            OP_POP_FRONT:  o_cmd_kind = CMD_POP_FRONT;
            OP_POP_BACK:   o_cmd_kind = CMD_POP_BACK;
            OP_REMOVE:     o_cmd_kind = CMD_REMOVE;
            default:       o_cmd_kind = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/bdra_cmdq.sv */
`default_nettype none

module bdra_cmdq
    import bdra_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int FW = $clog2(CMDQ_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [CMDQ_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FW-1:0]    r_fill, n_fill;
    logic             push, pop;

    assign o_ready = r_fill != FW'(CMDQ_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_slot[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bdra_back.sv */
`default_nettype none

module bdra_back
    import bdra_pkg::*;
#(
    parameter int DEPTH      = BDRA_DEPTH,
    parameter int DATA_WIDTH = BDRA_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    output logic                       o_cmd_ready,
    input  wire t_cmd_kind             i_cmd_kind,
    input  wire logic [DATA_WIDTH-1:0] i_cmd_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_result                    o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
        return (x == AW'(DEPTH - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
        return (x == '0) ? AW'(DEPTH - 1) : x - 1'b1;
    endfunction

    function automatic logic [31:0] to_word(input logic [DATA_WIDTH-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

    function automatic logic [6:0] to_count(input logic [CW-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[6:0];
    endfunction

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    t_back_state           r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;
    t_cmd_kind             r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [DATA_WIDTH-1:0] r_pop_word, n_pop_word;
    logic [AW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]         r_left, n_left;
    logic [CW-1:0]         r_kept, n_kept;
    logic                  r_out_valid, n_out_valid;
    t_result               r_result, n_result;

    logic                  slot_free, start, is_full, is_empty;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_wa, mem_ra;
    logic [DATA_WIDTH-1:0] mem_wd;
    logic                  res_load;
    t_status               res_status;
    logic [31:0]           res_popped;
    logic [CW-1:0]         res_removed;

    assign slot_free   = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == BK_IDLE) && slot_free;
    assign start       = o_cmd_ready && i_cmd_valid;
    assign is_full     = r_count == CW'(DEPTH);
    assign is_empty    = r_count == '0;
    assign o_valid     = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (start && !is_empty) begin
                    case (i_cmd_kind)
                        CMD_POP_FRONT, CMD_POP_BACK: n_state = BK_POP_WAIT;
                        CMD_REMOVE:                  n_state = BK_SCAN;
                        default:                     n_state = BK_IDLE;
                    endcase
                end
            end
            BK_POP_WAIT: n_state = BK_IDLE;
            BK_SCAN: begin
                if (r_left == '0) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_kind      = r_kind;
        n_value     = r_value;
        n_pop_word  = r_pop_word;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_left      = r_left;
        n_kept      = r_kept;
        mem_we      = 1'b0;
        mem_wa      = r_wr_ptr;
        mem_wd      = r_mem_q;
        mem_re      = 1'b0;
        mem_ra      = r_rd_ptr;
        res_load    = 1'b0;
        res_status  = STAT_OK;
        res_popped  = '0;
        res_removed = '0;

        case (r_state)
            BK_IDLE: begin
                if (start) begin
                    n_kind  = i_cmd_kind;
                    n_value = i_cmd_value;
                    case (i_cmd_kind)
                        CMD_PUSH_FRONT: begin
                            res_load = 1'b1;
                            if (is_full) begin
                                res_status = STAT_PUSH_FULL;
                            end else begin
                                n_head  = ring_dec(r_head);
                                mem_we  = 1'b1;
                                mem_wa  = n_head;
                                mem_wd  = i_cmd_value;
                                n_count = r_count + 1'b1;
                                n_front = i_cmd_value;
                                if (is_empty) begin
                                    n_back = i_cmd_value;
                                end
                            end
                        end
                        CMD_PUSH_BACK: begin
                            res_load = 1'b1;
                            if (is_full) begin
                                res_status = STAT_PUSH_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = r_tail;
                                mem_wd  = i_cmd_value;
                                n_tail  = ring_inc(r_tail);
                                n_count = r_count + 1'b1;
                                n_back  = i_cmd_value;
                                if (is_empty) begin
                                    n_front = i_cmd_value;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (is_empty) begin
                                res_load   = 1'b1;
                                res_status = STAT_POP_EMPTY;
                            end else begin
                                n_pop_word = r_front;
                                n_head     = ring_inc(r_head);
                                mem_re     = 1'b1;
                                mem_ra     = n_head;
                                n_count    = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (is_empty) begin
                                res_load   = 1'b1;
                                res_status = STAT_POP_EMPTY;
                            end else begin
                                n_pop_word = r_back;
                                n_tail     = ring_dec(r_tail);
                                mem_re     = 1'b1;
                                mem_ra     = ring_dec(n_tail);
                                n_count    = r_count - 1'b1;
                            end
                        end
                        CMD_REMOVE: begin
                            if (is_empty) begin
                                res_load   = 1'b1;
                                res_status = STAT_NOT_FOUND;
                            end else begin
                                mem_re   = 1'b1;
                                mem_ra   = r_head;
                                n_rd_ptr = ring_inc(r_head);
                                n_wr_ptr = r_head;
                                n_left   = r_count - 1'b1;
                                n_kept   = '0;
                            end
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP_WAIT: begin
                if (r_kind == CMD_POP_FRONT) begin
                    n_front = r_mem_q;
                end else begin
                    n_back = r_mem_q;
                end
                res_popped = to_word(r_pop_word);
                res_load   = 1'b1;
            end
            BK_SCAN: begin
                if (r_left != '0) begin
                    mem_re   = 1'b1;
                    mem_ra   = r_rd_ptr;
                    n_rd_ptr = ring_inc(r_rd_ptr);
                    n_left   = r_left - 1'b1;
                end
                // keep the entry and close the gap
                if (r_mem_q != r_value) begin
                    mem_we   = 1'b1;
                    mem_wa   = r_wr_ptr;
                    mem_wd   = r_mem_q;
                    n_wr_ptr = ring_inc(r_wr_ptr);
                    n_kept   = r_kept + 1'b1;
                    n_back   = r_mem_q;
                    if (r_kept == '0) begin
                        n_front = r_mem_q;
                    end
                end
                if (r_left == '0) begin
                    n_count     = n_kept;
                    n_tail      = n_wr_ptr;
                    res_removed = r_count - n_kept;
                    res_status  = (res_removed == '0) ? STAT_NOT_FOUND : STAT_OK;
                    res_load    = 1'b1;
                end
            end
            default: begin
                res_load = 1'b0;
            end
        endcase

        n_result.popped_value  = res_popped;
        n_result.status        = res_status;
        n_result.removed_count = to_count(res_removed);
        n_result.front_value   = (n_count == '0) ? '0 : to_word(n_front);
        n_result.back_value    = (n_count == '0) ? '0 : to_word(n_back);
        n_result.is_empty      = n_count == '0;
        n_result.is_full       = n_count == CW'(DEPTH);
        n_result.entry_count   = to_count(n_count);

        if (res_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front    <= n_front;
        r_back     <= n_back;
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_pop_word <= n_pop_word;
        r_rd_ptr   <= n_rd_ptr;
        r_wr_ptr   <= n_wr_ptr;
        r_left     <= n_left;
        r_kept     <= n_kept;
        if (res_load) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bounded_deque_remove_all.sv */
`default_nettype none

// Bounded double-ended queue of DATA_WIDTH-bit words kept in a ring memory of
// DEPTH entries, with push and pop at both ends and a remove-all-equal that
// compacts the survivors in order. Every item gives one result carrying the
// status and the queue as it stands after that item. A two-entry command queue
// sits behind the input, so up to two items are taken while the executor is
// busy. Push, remove on an empty queue and unused codes give their result from
// the idle state; a pop waits in a read-wait state for one registered read of
// the ring memory to find the new end word, unless the queue is empty; a remove
// walks the held entries, reading one entry a cycle through the single read
// port. The result is held in an output register, and a new item is started
// only when that register is free or being taken in the same cycle.
module bounded_deque_remove_all
    import bdra_pkg::*;
#(
    parameter int DEPTH      = BDRA_DEPTH,
    parameter int DATA_WIDTH = BDRA_DATA_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_item   i_item,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    localparam int KW = $bits(t_cmd_kind);
    localparam int QW = KW + DATA_WIDTH;

    logic                  f_valid, f_ready;
    t_cmd_kind             f_kind;
    logic [DATA_WIDTH-1:0] f_value;
    logic [QW-1:0]         q_in, q_out;
    logic                  b_valid, b_ready;
    t_cmd_kind             b_kind;
    logic [DATA_WIDTH-1:0] b_value;

    bdra_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd_kind  (f_kind),
        .o_cmd_value (f_value)
    );

    assign q_in = {f_kind, f_value};

    bdra_cmdq #(
        .WIDTH (QW)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (b_valid),
        .i_ready (b_ready),
        .o_data  (q_out)
    );

    assign b_kind  = t_cmd_kind'(q_out[QW-1 -: KW]);
    assign b_value = q_out[DATA_WIDTH-1:0];

    bdra_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (b_valid),
        .o_cmd_ready (b_ready),
        .i_cmd_kind  (b_kind),
        .i_cmd_value (b_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.is_empty |->
            o_result.front_value == '0 && o_result.back_value == '0 &&
            o_result.entry_count == '0)
        else $error("empty result carries stale words");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.is_empty && o_result.is_full))
        else $error("result both empty and full");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == STAT_POP_EMPTY |->
            o_result.is_empty && o_result.popped_value == '0)
        else $error("pop on empty with data or entries");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == STAT_PUSH_FULL |-> o_result.is_full)
        else $error("push dropped while not full");

endmodule

`default_nettype wire
